// File: src/wlcc_pkg.sv
// Package for the wavetable LFO to control-change block.
// Holds widths, codes, the microprogram table and the structs shared by all modules.
// Depends on nothing.
`default_nettype none

package wlcc_pkg;

   // Table geometry.
   localparam int TABLE_LEN   = 256;
   localparam int IDX_W       = 8;
   localparam int BODY_COUNT  = 3;
   localparam int BODY_W      = 2;
   localparam int TABLE_DEPTH = BODY_COUNT * TABLE_LEN;
   localparam int ADDR_W      = BODY_W + IDX_W;

   // Field and arithmetic widths.
   localparam int POS_W    = 16;
   localparam int PHASE_W  = 32;
   localparam int FRAC_W   = 16;
   localparam int RECIP_W  = 24;
   localparam int CC_W     = 7;
   localparam int SENT_W   = 8;
   localparam int DIFF_W   = POS_W + 1;
   localparam int X_W      = 34;
   localparam int Y_W      = 58;
   localparam int T_W      = 65;
   localparam int CC_SHIFT = 33;

   localparam logic [SENT_W-1:0] NOTHING_SENT = 8'd128;
   localparam logic [CC_W-1:0]   CC_MAX       = 7'd127;
   localparam logic signed [Y_W-1:0] Q_BIAS   = {{(Y_W - 33){1'b0}}, 1'b1, 32'b0};

   // Configuration register indexes and reset values.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXTENT_RECIP     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTROLLER_ONE   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTROLLER_TWO   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTROLLER_THREE = 3'd4;

   localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 32'd2983;
   localparam logic [RECIP_W-1:0] RECIP_RESET      = 24'd65536;
   localparam logic [BODY_COUNT-1:0][CC_W-1:0] CTRL_RESET = {7'd22, 7'd21, 7'd20};

   // Operation codes carried on the request side.
   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_TICK    = 2'd1,
      OP_RESTART = 2'd2
   } op_type;

   // Microprogram steps.
   typedef logic [3:0] step_type;
   localparam step_type ST_IDLE      = 4'd0;
   localparam step_type ST_RD_A      = 4'd1;
   localparam step_type ST_RD_B      = 4'd2;
   localparam step_type ST_MUL_FRAC  = 4'd3;
   localparam step_type ST_FORM_X    = 4'd4;
   localparam step_type ST_MUL_RECIP = 4'd5;
   localparam step_type ST_BIAS      = 4'd6;
   localparam step_type ST_DECIDE    = 4'd7;
   localparam step_type ST_EMIT      = 4'd8;
   localparam step_type ST_DONE      = 4'd9;

   typedef enum logic [1:0] {
      JMP_NEXT      = 2'd0,
      JMP_GOTO      = 2'd1,
      JMP_BODY_LOOP = 2'd2
   } jump_type;

   // One control word of the microprogram.
   typedef struct packed {
      logic     wait_item;
      logic     rd_a;
      logic     rd_b;
      logic     mul_frac;
      logic     form_x;
      logic     mul_recip;
      logic     bias;
      logic     decide;
      logic     emit;
      jump_type jmp;
      step_type target;
   } ctl_type;

   // Table write request.
   typedef struct packed {
      logic                    en;
      logic [ADDR_W-1:0]       addr;
      logic signed [POS_W-1:0] data;
   } wr_type;

   // Per-tick results handed to the output stage.
   typedef struct packed {
      logic [BODY_COUNT-1:0]           changed;
      logic [BODY_COUNT-1:0][CC_W-1:0] cc;
   } res_type;

   // The microprogram itself.
   function automatic ctl_type ucode(input step_type step);
      ctl_type c;
      c        = '0;
      c.jmp    = JMP_NEXT;
      c.target = ST_IDLE;
      case (step)
         ST_IDLE:      c.wait_item = 1'b1;
         ST_RD_A:      c.rd_a      = 1'b1;
         ST_RD_B:      c.rd_b      = 1'b1;
         ST_MUL_FRAC:  c.mul_frac  = 1'b1;
         ST_FORM_X:    c.form_x    = 1'b1;
         ST_MUL_RECIP: c.mul_recip = 1'b1;
         ST_BIAS:      c.bias      = 1'b1;
         ST_DECIDE: begin
            c.decide = 1'b1;
            c.jmp    = JMP_BODY_LOOP;
            c.target = ST_RD_A;
         end
         ST_EMIT: begin
            c.emit   = 1'b1;
            c.jmp    = JMP_BODY_LOOP;
            c.target = ST_EMIT;
         end
         default: c.jmp = JMP_GOTO;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// File: src/wavetable_lfo_to_cc_top.sv
// Top level of the wavetable LFO to control-change block.
// Instantiates wlcc_seq and wlcc_dp; holds configuration, phase and the output register.
`default_nettype none

// Three looped position tables of 256 signed 16-bit entries, one per body, are filled by
// load items (tuser = load). A tick item reads every body's table at the current 32-bit
// loop phase, interpolates linearly between neighbouring entries with 16 fractional bits,
// scales the value by the Q16 reciprocal-extent register, maps -1..+1 onto 0..127 with
// clamping, and sends one control-change item per body whose value differs from the one
// it last sent, in body order, with tlast on the final item of the tick. The phase then
// moves on by phase_step, wrapping. A restart item zeroes the phase. Table entries must be
// written before a tick reads them; a load to body three is dropped. Loads, restarts and
// unknown operations are taken without leaving the idle step. For a tick, a short
// microprogram runs seven steps per body through one shared memory read port, multiply
// and scale path, then one emit step per body and a closing step, waiting while the
// result side stalls, and the block takes no new item until it has finished.
// Configuration may be written at any cycle while no tick is in progress.
module wavetable_lfo_to_cc_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request side.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // body[1:0], entry_index[9:2], position[25:10], zero padding above.
   input  wire logic [31:0] req_tdata,
   // operation[1:0].
   input  wire logic [1:0]  req_tuser,
   // Result side.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // controller[6:0], cc_value[13:7], source_body[15:14].
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tlast,
   // Configuration writes.
   input  wire logic        csr_wr_en,
   input  wire logic [wlcc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [wlcc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [wlcc_pkg::PHASE_W-1:0]               phase_step_ff;
   logic [wlcc_pkg::RECIP_W-1:0]               recip_ff;
   logic [wlcc_pkg::BODY_COUNT-1:0][wlcc_pkg::CC_W-1:0] ctrl_ff;
   logic [wlcc_pkg::PHASE_W-1:0]               phase_ff, phase_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_last_ff;
   logic [wlcc_pkg::CC_W-1:0]     rsp_ctrl_ff;
   logic [wlcc_pkg::CC_W-1:0]     rsp_cc_ff;
   logic [wlcc_pkg::BODY_W-1:0]   rsp_body_ff;

   wlcc_pkg::ctl_type             ctl;
   wlcc_pkg::res_type             res;
   wlcc_pkg::wr_type              wr;
   logic [wlcc_pkg::BODY_W-1:0]   body;

   logic                          req_go;
   wlcc_pkg::op_type              op;
   logic [wlcc_pkg::BODY_W-1:0]   req_body;
   logic                          tick_go;
   logic                          send;
   logic                          emit_hold;
   logic                          later_change;

   // Items are taken only while the microprogram waits at its idle step.
   assign req_tready = ctl.wait_item;
   assign req_go     = req_tvalid && req_tready;
   assign op         = wlcc_pkg::op_type'(req_tuser);
   assign req_body   = req_tdata[1:0];
   assign tick_go    = req_go && (op == wlcc_pkg::OP_TICK);

   assign wr.en   = req_go && (op == wlcc_pkg::OP_LOAD) &&
                    (req_body < wlcc_pkg::BODY_W'(wlcc_pkg::BODY_COUNT));
   assign wr.addr = {req_body, req_tdata[9:2]};
   assign wr.data = signed'(req_tdata[25:10]);

   // Phase: the tick samples it and then advances it in the same cycle.
   always_comb begin
      phase_in = phase_ff;
      if (req_go && (op == wlcc_pkg::OP_RESTART)) begin
         phase_in = '0;
      end else if (tick_go) begin
         phase_in = phase_ff + phase_step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= wlcc_pkg::PHASE_STEP_RESET;
         recip_ff      <= wlcc_pkg::RECIP_RESET;
         ctrl_ff       <= wlcc_pkg::CTRL_RESET;
         phase_ff      <= '0;
      end else begin
         phase_ff <= phase_in;
         if (csr_wr_en) begin
            case (csr_index)
               wlcc_pkg::CSR_PHASE_STEP:       phase_step_ff <= csr_wdata;
               wlcc_pkg::CSR_EXTENT_RECIP:     recip_ff <= csr_wdata[wlcc_pkg::RECIP_W-1:0];
               wlcc_pkg::CSR_CONTROLLER_ONE:   ctrl_ff[0] <= csr_wdata[wlcc_pkg::CC_W-1:0];
               wlcc_pkg::CSR_CONTROLLER_TWO:   ctrl_ff[1] <= csr_wdata[wlcc_pkg::CC_W-1:0];
               wlcc_pkg::CSR_CONTROLLER_THREE: ctrl_ff[2] <= csr_wdata[wlcc_pkg::CC_W-1:0];
               default: ;
            endcase
         end
      end
   end

   wlcc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .tick_go   (tick_go),
      .emit_hold (emit_hold),
      .ctl       (ctl),
      .body      (body)
   );

   wlcc_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .body    (body),
      .tick_go (tick_go),
      .phase   (phase_ff),
      .wr      (wr),
      .recip   (recip_ff),
      .res     (res)
   );

   // A body with no later changed body carries the tick's last item.
   always_comb begin
      later_change = 1'b0;
      for (int i = 0; i < wlcc_pkg::BODY_COUNT; i++) begin
         if (res.changed[i] && (wlcc_pkg::BODY_W'(i) > body)) begin
            later_change = 1'b1;
         end
      end
   end

   // The emit step waits while the output register still holds an untaken item.
   assign emit_hold = ctl.emit && res.changed[body] && rsp_valid_ff && !rsp_tready;
   assign send      = ctl.emit && res.changed[body] && !emit_hold;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (send) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (send) begin
         rsp_ctrl_ff <= ctrl_ff[body];
         rsp_cc_ff   <= res.cc[body];
         rsp_body_ff <= body;
         rsp_last_ff <= !later_change;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_body_ff, rsp_cc_ff, rsp_ctrl_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// File: src/wlcc_seq.sv
// Microprogram sequencer: step counter, body counter and jump logic.
// Reads its control words from the table in wlcc_pkg.
`default_nettype none

module wlcc_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          tick_go,
   input  wire logic                          emit_hold,
   output wlcc_pkg::ctl_type                  ctl,
   output logic [wlcc_pkg::BODY_W-1:0]        body
);

   wlcc_pkg::step_type                 step_ff, step_in;
   logic [wlcc_pkg::BODY_W-1:0]        body_ff, body_in;

   assign ctl  = wlcc_pkg::ucode(step_ff);
   assign body = body_ff;

   always_comb begin
      step_in = step_ff;
      body_in = body_ff;
      if (!emit_hold) begin
         case (ctl.jmp)
            wlcc_pkg::JMP_NEXT: begin
               if (!ctl.wait_item || tick_go) begin
                  step_in = step_ff + 4'd1;
               end
            end
            wlcc_pkg::JMP_GOTO: step_in = ctl.target;
            wlcc_pkg::JMP_BODY_LOOP: begin
               if (body_ff != wlcc_pkg::BODY_W'(wlcc_pkg::BODY_COUNT - 1)) begin
                  body_in = body_ff + 2'd1;
                  step_in = ctl.target;
               end else begin
                  body_in = '0;
                  step_in = step_ff + 4'd1;
               end
            end
            default: step_in = wlcc_pkg::ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= wlcc_pkg::ST_IDLE;
         body_ff <= '0;
      end else begin
         step_ff <= step_in;
         body_ff <= body_in;
      end
   end

   // The body counter never names a table that does not exist.
   a_body_range: assert property (@(posedge clock) disable iff (reset)
      body_ff != 2'd3)
      else $error("body counter out of range");

   // Every tick starts its body loop at the first body.
   a_idle_body: assert property (@(posedge clock) disable iff (reset)
      ctl.wait_item |-> body_ff == '0)
      else $error("body counter not cleared at idle");

   // A stalled emit keeps the sequencer where it is.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      emit_hold |=> $stable(step_ff) && $stable(body_ff))
      else $error("sequencer moved during an output stall");

endmodule

`default_nettype wire

// File: src/wlcc_dp.sv
// Datapath: position table memory, interpolation, scaling and change detection.
// Driven by control words from wlcc_seq; uses types from wlcc_pkg.
`default_nettype none

module wlcc_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire wlcc_pkg::ctl_type                 ctl,
   input  wire logic [wlcc_pkg::BODY_W-1:0]       body,
   input  wire logic                              tick_go,
   input  wire logic [wlcc_pkg::PHASE_W-1:0]      phase,
   input  wire wlcc_pkg::wr_type                  wr,
   input  wire logic [wlcc_pkg::RECIP_W-1:0]      recip,
   output wlcc_pkg::res_type                      res
);

   logic signed [wlcc_pkg::POS_W-1:0] table_mem [wlcc_pkg::TABLE_DEPTH];

   logic [wlcc_pkg::IDX_W-1:0]         idx_ff;
   logic [wlcc_pkg::FRAC_W-1:0]        frac_ff;
   logic signed [wlcc_pkg::POS_W-1:0]  rdata_ff;
   logic signed [wlcc_pkg::POS_W-1:0]  a_ff;
   logic signed [wlcc_pkg::X_W-1:0]    dfrac_ff, dfrac_in;
   logic signed [wlcc_pkg::X_W-1:0]    x_ff, x_in;
   logic signed [wlcc_pkg::Y_W-1:0]    y_ff, y_in;
   logic signed [wlcc_pkg::Y_W-1:0]    yb_ff, yb_in;
   logic [wlcc_pkg::BODY_COUNT-1:0][wlcc_pkg::CC_W-1:0] cc_ff;
   logic [wlcc_pkg::BODY_COUNT-1:0]    changed_ff;
   logic [wlcc_pkg::SENT_W-1:0]        last_sent_ff [wlcc_pkg::BODY_COUNT];

   logic [wlcc_pkg::ADDR_W-1:0]        rd_addr;
   logic signed [wlcc_pkg::DIFF_W-1:0] diff;
   logic signed [wlcc_pkg::DIFF_W-1:0] frac_s;
   logic signed [wlcc_pkg::T_W-1:0]    t;
   logic [wlcc_pkg::CC_W-1:0]          cc;
   logic                               cc_changed;

   // The upper neighbour wraps to entry zero with the index width.
   assign rd_addr = ctl.rd_b ? {body, idx_ff + 8'd1} : {body, idx_ff};

   always_ff @(posedge clock) begin
      if (wr.en) begin
         table_mem[wr.addr] <= wr.data;
      end
      if (ctl.rd_a || ctl.rd_b) begin
         rdata_ff <= table_mem[rd_addr];
      end
   end

   // x = a * 65536 + (b - a) * frac, exact.
   assign diff     = wlcc_pkg::DIFF_W'(rdata_ff) - wlcc_pkg::DIFF_W'(a_ff);
   assign frac_s   = signed'({1'b0, frac_ff});
   assign dfrac_in = wlcc_pkg::X_W'(diff) * wlcc_pkg::X_W'(frac_s);
   assign x_in     = (wlcc_pkg::X_W'(a_ff) <<< wlcc_pkg::FRAC_W) + dfrac_ff;
   assign y_in     = wlcc_pkg::Y_W'(x_ff) * wlcc_pkg::Y_W'(signed'({1'b0, recip}));
   assign yb_in    = y_ff + wlcc_pkg::Q_BIAS;

   // Multiply by 127 as a shift and subtract, then clamp to the controller range.
   assign t = (wlcc_pkg::T_W'(yb_ff) <<< 7) - wlcc_pkg::T_W'(yb_ff);

   always_comb begin
      if (t[wlcc_pkg::T_W-1] || (t == '0)) begin
         cc = '0;
      end else if (|t[wlcc_pkg::T_W-2:wlcc_pkg::CC_SHIFT+wlcc_pkg::CC_W]) begin
         cc = wlcc_pkg::CC_MAX;
      end else begin
         cc = t[wlcc_pkg::CC_SHIFT+wlcc_pkg::CC_W-1:wlcc_pkg::CC_SHIFT];
      end
   end

   assign cc_changed = {1'b0, cc} != last_sent_ff[body];

   always_ff @(posedge clock) begin
      if (tick_go) begin
         idx_ff  <= phase[wlcc_pkg::PHASE_W-1 -: wlcc_pkg::IDX_W];
         frac_ff <= phase[wlcc_pkg::PHASE_W-wlcc_pkg::IDX_W-1 -: wlcc_pkg::FRAC_W];
      end
      if (ctl.rd_b)      a_ff     <= rdata_ff;
      if (ctl.mul_frac)  dfrac_ff <= dfrac_in;
      if (ctl.form_x)    x_ff     <= x_in;
      if (ctl.mul_recip) y_ff     <= y_in;
      if (ctl.bias)      yb_ff    <= yb_in;
      if (ctl.decide) begin
         cc_ff[body]      <= cc;
         changed_ff[body] <= cc_changed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < wlcc_pkg::BODY_COUNT; i++) begin
            last_sent_ff[i] <= wlcc_pkg::NOTHING_SENT;
         end
      end else if (ctl.decide && cc_changed) begin
         last_sent_ff[body] <= {1'b0, cc};
      end
   end

   assign res.changed = changed_ff;
   assign res.cc      = cc_ff;

endmodule

`default_nettype wire

// File: tb/tb_wavetable_lfo_to_cc_top.sv
// Self-checking testbench for wavetable_lfo_to_cc_top: drives load, tick and restart items
// on the request stream and checks every control-change item against a built-in predictor.
// Depends on wlcc_pkg and the wavetable_lfo_to_cc_top RTL.
`timescale 1ns / 1ps

module tb_wavetable_lfo_to_cc_top;

   // The operation code that the block must ignore.
   localparam logic [1:0] OP_UNKNOWN = 2'd3;
   // Covers a tick that is still running after the last expected item has arrived.
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 400000;
   // Items queued per random phase, counting the loads that a tick brings with it.
   localparam int PHASE_ITEMS   = 37;

   typedef struct packed {
      logic [1:0]  op;
      logic [1:0]  body;
      logic [7:0]  idx;
      logic [15:0] pos;
   } lfo_request_type;

   typedef struct packed {
      logic [6:0] controller;
      logic [6:0] cc_value;
      logic [1:0] source_body;
      logic       last;
   } cc_change_type;

   // Clock, reset and the ports of the block; every input starts at a known value.
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en  = 1'b0;
   logic [wlcc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [wlcc_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   wavetable_lfo_to_cc_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Predictor state: its own copy of the tables, phase, configuration and the level that
   // was last sent for each body.
   logic signed [15:0] lfo_table [wlcc_pkg::BODY_COUNT][wlcc_pkg::TABLE_LEN];
   logic [31:0]        lfo_phase;
   logic [31:0]        lfo_step;
   logic [23:0]        lfo_recip;
   logic [6:0]         lfo_ctrl [wlcc_pkg::BODY_COUNT];
   logic [7:0]         lfo_sent [wlcc_pkg::BODY_COUNT];
   cc_change_type      cc_expected [$];

   // Stimulus side: items waiting to be driven, and a shadow of the phase and of which
   // table entries hold a value, so that a tick never reads an entry never written.
   lfo_request_type req_backlog [$];
   logic [31:0]     gen_phase;
   logic [31:0]     gen_step;
   bit              gen_written [wlcc_pkg::BODY_COUNT][wlcc_pkg::TABLE_LEN];

   // Handshake bookkeeping, idling and counters.
   logic req_taken = 1'b0;
   int   req_gap   = 0;
   int   rsp_gap   = 0;
   bit   calm      = 1'b0;
   int   cycle_count   = 0;
   int   fail_count    = 0;
   int   changes_seen  = 0;
   int   loads_seen    = 0;
   int   ticks_seen    = 0;
   int   others_seen   = 0;
   int   settings_seen = 1;

   // Free-running clock with a 4 ns period.
   initial begin
      forever #2 clock = ~clock;
   end

   // Level of one body: linear interpolation in Q16, scaling by the reciprocal extent,
   // then mapping -1..+1 onto 0..127 with clamping at both ends.
   function automatic logic [6:0] body_level(input int b, input logic [7:0] i0,
                                             input logic [7:0] i1, input logic [15:0] frac);
      longint lo;
      longint hi;
      longint x;
      longint t;
      lo = longint'(lfo_table[b][i0]);
      hi = longint'(lfo_table[b][i1]);
      x  = lo * (longint'(65536) - longint'(frac)) + hi * longint'(frac);
      t  = (x * longint'(lfo_recip) + (longint'(1) <<< 32)) * 127;
      if (t <= 0)
         return 7'd0;
      if ((t >>> 33) > 127)
         return 7'd127;
      return 7'(t >>> 33);
   endfunction

   // Applies one accepted request to the predictor and queues the changes it causes.
   task automatic predict_changes(input logic [1:0] op, input logic [31:0] data);
      logic [7:0]    i0;
      logic [7:0]    i1;
      logic [15:0]   frac;
      logic [6:0]    lvl;
      cc_change_type msgs [wlcc_pkg::BODY_COUNT];
      int            n;
      n = 0;
      case (op)
         wlcc_pkg::OP_LOAD: begin
            // A load to body three is dropped.
            if (data[1:0] < wlcc_pkg::BODY_COUNT)
               lfo_table[data[1:0]][data[9:2]] = data[25:10];
            loads_seen++;
         end
         wlcc_pkg::OP_RESTART: begin
            lfo_phase = '0;
            others_seen++;
         end
         wlcc_pkg::OP_TICK: begin
            i0   = lfo_phase[31:24];
            i1   = i0 + 8'd1;
            frac = lfo_phase[23:8];
            for (int b = 0; b < wlcc_pkg::BODY_COUNT; b++) begin
               lvl = body_level(b, i0, i1, frac);
               if ({1'b0, lvl} != lfo_sent[b]) begin
                  msgs[n].controller  = lfo_ctrl[b];
                  msgs[n].cc_value    = lvl;
                  msgs[n].source_body = 2'(b);
                  msgs[n].last        = 1'b0;
                  lfo_sent[b]         = {1'b0, lvl};
                  n++;
               end
            end
            if (n > 0)
               msgs[n-1].last = 1'b1;
            for (int k = 0; k < n; k++)
               cc_expected.push_back(msgs[k]);
            lfo_phase = lfo_phase + lfo_step;
            ticks_seen++;
         end
         default: others_seen++;
      endcase
   endtask

   // Monitor: samples both handshakes at the rising edge, checks each result item against
   // the oldest expectation and feeds each accepted request to the predictor.
   always @(posedge clock) begin
      cc_change_type got;
      cc_change_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timed out after %0d cycles with %0d changes outstanding",
                  $time, cycle_count, cc_expected.size());
         $display("Regression FAIL");
         $finish;
      end else if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got.controller  = rsp_tdata[6:0];
            got.cc_value    = rsp_tdata[13:7];
            got.source_body = rsp_tdata[15:14];
            got.last        = rsp_tlast;
            if (cc_expected.size() == 0) begin
               $display({"%0t: unexpected change: expected none, ",
                         "actual ctrl %0d value %0d body %0d last %0d"},
                        $time, got.controller, got.cc_value, got.source_body, got.last);
               fail_count++;
            end else begin
               want = cc_expected.pop_front();
               if (got.controller !== want.controller || got.cc_value !== want.cc_value ||
                   got.source_body !== want.source_body || got.last !== want.last) begin
                  $display({"%0t: change mismatch: ",
                            "expected ctrl %0d value %0d body %0d last %0d, ",
                            "actual ctrl %0d value %0d body %0d last %0d"},
                           $time, want.controller, want.cc_value, want.source_body,
                           want.last, got.controller, got.cc_value, got.source_body,
                           got.last);
                  fail_count++;
               end
               changes_seen++;
            end
         end
         if (req_tvalid && req_tready)
            predict_changes(req_tuser, req_tdata);
      end
   end

   // Request driver: holds an item until it is taken, otherwise either idles at random or
   // presents the next item from the backlog.
   always @(negedge clock) begin
      lfo_request_type nxt;
      if (req_tvalid && !req_taken) begin
         // Item still on offer; hold it.
      end else if (req_gap > 0) begin
         req_gap    <= req_gap - 1;
         req_tvalid <= 1'b0;
      end else if (req_backlog.size() > 0) begin
         if (!calm && $urandom_range(0, 9) == 0) begin
            req_gap    <= $urandom_range(0, 5);
            req_tvalid <= 1'b0;
         end else begin
            nxt = req_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {6'b0, nxt.pos, nxt.idx, nxt.body};
            req_tuser  <= nxt.op;
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Result side: stalls at random, never in the calm stretch.
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap    <= rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_gap    <= $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic lfo_request_type make_request(input logic [1:0] op,
                                                    input logic [1:0] body,
                                                    input logic [7:0] idx,
                                                    input logic [15:0] pos);
      lfo_request_type r;
      r.op   = op;
      r.body = body;
      r.idx  = idx;
      r.pos  = pos;
      return r;
   endfunction

   // Half of the positions span the full range, the rest sit close to zero so that a
   // large reciprocal extent still lands between the clamps.
   function automatic logic [15:0] random_position();
      if ($urandom_range(0, 1) == 0)
         return 16'($urandom);
      return 16'($urandom_range(0, 511) - 256);
   endfunction

   task automatic queue_load(input logic [1:0] body, input logic [7:0] idx,
                             input logic [15:0] pos);
      req_backlog.push_back(make_request(wlcc_pkg::OP_LOAD, body, idx, pos));
      if (body < wlcc_pkg::BODY_COUNT)
         gen_written[body][idx] = 1'b1;
   endtask

   // A tick reads entries i0 and i0 + 1 of every body; any that were never written are
   // loaded first. The unused fields of the tick carry random bits.
   task automatic queue_tick();
      logic [7:0] i0;
      logic [7:0] j;
      i0 = gen_phase[31:24];
      for (int b = 0; b < wlcc_pkg::BODY_COUNT; b++) begin
         for (int k = 0; k < 2; k++) begin
            j = i0 + 8'(k);
            if (!gen_written[b][j])
               queue_load(2'(b), j, random_position());
         end
      end
      req_backlog.push_back(make_request(wlcc_pkg::OP_TICK, 2'($urandom), 8'($urandom),
                                         16'($urandom)));
      gen_phase = gen_phase + gen_step;
   endtask

   task automatic queue_restart();
      req_backlog.push_back(make_request(wlcc_pkg::OP_RESTART, 2'($urandom), 8'($urandom),
                                         16'($urandom)));
      gen_phase = '0;
   endtask

   // Mostly ticks and loads, with some restarts and unknown operations as noise.
   task automatic queue_random_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         queue_tick();
      else if (r < 85)
         queue_load(2'($urandom_range(0, 3)), 8'($urandom), random_position());
      else if (r < 93)
         queue_restart();
      else
         req_backlog.push_back(make_request(OP_UNKNOWN, 2'($urandom), 8'($urandom),
                                            16'($urandom)));
   endtask

   // Writes one register on the plain write port and in the predictor alike.
   task automatic write_register(input logic [wlcc_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [31:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wdata = value;
      case (index)
         wlcc_pkg::CSR_PHASE_STEP: begin
            lfo_step = value;
            gen_step = value;
         end
         wlcc_pkg::CSR_EXTENT_RECIP:     lfo_recip   = value[23:0];
         wlcc_pkg::CSR_CONTROLLER_ONE:   lfo_ctrl[0] = value[6:0];
         wlcc_pkg::CSR_CONTROLLER_TWO:   lfo_ctrl[1] = value[6:0];
         wlcc_pkg::CSR_CONTROLLER_THREE: lfo_ctrl[2] = value[6:0];
         default: ;
      endcase
   endtask

   // Writes every register, then hands back at a rising edge so that newly queued items
   // never race with the driver.
   task automatic set_registers(input logic [31:0] step, input logic [23:0] recip,
                                input logic [6:0] c1, input logic [6:0] c2, input logic [6:0] c3);
      write_register(wlcc_pkg::CSR_PHASE_STEP, step);
      write_register(wlcc_pkg::CSR_EXTENT_RECIP, {8'd0, recip});
      write_register(wlcc_pkg::CSR_CONTROLLER_ONE, {25'd0, c1});
      write_register(wlcc_pkg::CSR_CONTROLLER_TWO, {25'd0, c2});
      write_register(wlcc_pkg::CSR_CONTROLLER_THREE, {25'd0, c3});
      @(negedge clock);
      csr_wr_en = 1'b0;
      @(posedge clock);
      settings_seen++;
   endtask

   // Waits until every item has been taken and every expected change has arrived, then
   // lets a tick that sends nothing run to its end before the block is treated as idle.
   task automatic settle();
      while (req_backlog.size() != 0 || req_tvalid || cc_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Stimulus sequence: a directed part at the reset settings and at the extremes, then
   // random phases under several register settings, the last without any idling.
   initial begin
      logic [31:0] step;
      logic [23:0] recip;

      lfo_phase = '0;
      lfo_step  = wlcc_pkg::PHASE_STEP_RESET;
      lfo_recip = wlcc_pkg::RECIP_RESET;
      for (int b = 0; b < wlcc_pkg::BODY_COUNT; b++) begin
         lfo_ctrl[b] = wlcc_pkg::CTRL_RESET[b];
         lfo_sent[b] = wlcc_pkg::NOTHING_SENT;
         for (int i = 0; i < wlcc_pkg::TABLE_LEN; i++) begin
            lfo_table[b][i]   = '0;
            gen_written[b][i] = 1'b0;
         end
      end
      gen_phase = '0;
      gen_step  = wlcc_pkg::PHASE_STEP_RESET;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // Reset settings. The first tick sends all three bodies (full scale, zero scale and
      // mid scale). The second one moves the phase only a little, so nothing changes and
      // no item comes back. A load to body three and an unknown operation are ignored,
      // and the restart brings the phase back to zero, so only the reloaded body moves.
      queue_load(2'd0, 8'd0, 16'h7FFF);
      queue_load(2'd1, 8'd0, 16'h8000);
      queue_load(2'd2, 8'd0, 16'h0000);
      queue_load(2'd0, 8'd1, 16'h7FFF);
      queue_load(2'd1, 8'd1, 16'h8000);
      queue_load(2'd2, 8'd1, 16'hFFFF);
      queue_load(2'd3, 8'd0, 16'h1234);
      queue_tick();
      queue_tick();
      req_backlog.push_back(make_request(OP_UNKNOWN, 2'd3, 8'hFF, 16'hFFFF));
      queue_load(2'd0, 8'd0, 16'h0000);
      queue_restart();
      queue_tick();
      settle();

      // Extremes: the largest reciprocal extent and a step of almost a whole loop, so that the second
      // tick sits on the last entry and interpolates towards entry zero. Controller
      // numbers take both end values.
      set_registers(32'hFF00_0000, 24'hFF_FFFF, 7'd0, 7'd127, 7'h55);
      queue_load(2'd0, 8'd255, 16'h0001);
      queue_load(2'd1, 8'd255, 16'hFFFF);
      queue_load(2'd2, 8'd255, 16'h0000);
      repeat (5) queue_tick();
      queue_restart();
      queue_tick();
      settle();

      // Random phases. The settle at the end of each one also holds the sender back until
      // every expected change has come in.
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin
               step  = $urandom;
               recip = 24'd2;
            end
            1: begin
               step  = 32'd0;
               recip = 24'd1;
            end
            2: begin
               step  = 32'hFFFF_FFFF;
               recip = 24'd3;
            end
            3: begin
               // A zero reciprocal extent flattens every body to mid scale.
               step  = $urandom_range(1, 1 << 24);
               recip = 24'd0;
            end
            4: begin
               step  = $urandom;
               recip = wlcc_pkg::RECIP_RESET;
            end
            default: begin
               step  = $urandom;
               recip = 24'd2;
            end
         endcase
         set_registers(step, recip, 7'($urandom), 7'($urandom), 7'($urandom));
         if (p == 5)
            calm = 1'b1;
         while (req_backlog.size() < PHASE_ITEMS)
            queue_random_item();
         settle();
      end

      $display({"Drove %0d loads, %0d ticks and %0d restarts or unknown operations ",
                "under %0d register settings;"},
               loads_seen, ticks_seen, others_seen, settings_seen);
      $display("checked %0d control-change items, %0d of them wrong.", changes_seen, fail_count);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
